@@ rtl/core/eavt_pkg.sv @@
// Shared widths, register indexes, reset values and types for the encoder tracker.
package eavt_pkg;

    // Field widths.
    localparam int ANGLE_BITS    = 12;
    localparam int ACCUM_BITS    = 32;
    localparam int VEL_FRAC_BITS = 16;
    localparam int VEL_BITS      = ANGLE_BITS + VEL_FRAC_BITS;
    localparam int ALPHA_BITS    = 16;
    localparam int POLE_BITS     = 7;

    // Configuration port.
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = ALPHA_BITS;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_FILTER_ALPHA      = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_POLE_PAIRS        = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_REVERSE_DIRECTION = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ELECTRICAL_ZERO   = 2'd3;

    // Register reset values.
    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd9362;
    localparam logic [POLE_BITS-1:0]  POLE_RESET  = 7'd7;

    // Request modes.
    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_INIT   = 1'b1;

    // Configuration register set.
    typedef struct packed {
        logic [ALPHA_BITS-1:0] alpha;
        logic [POLE_BITS-1:0]  pole_pairs;
        logic                  reverse;
        logic [ANGLE_BITS-1:0] zero;
    } eavt_cfg_t;

    // Tracking values produced for one request.
    typedef struct packed {
        logic signed [VEL_BITS-1:0]   velocity;
        logic signed [ACCUM_BITS-1:0] accum;
    } eavt_track_t;

endpackage

@@ rtl/core/eavt_elec.sv @@
// Electrical angle from a mechanical sample, pole pairs, direction and zero offset.
module eavt_elec (
    input  logic [eavt_pkg::ANGLE_BITS-1:0] raw_angle,
    input  eavt_pkg::eavt_cfg_t             cfg,
    output logic [eavt_pkg::ANGLE_BITS-1:0] elec_angle
);

    localparam int PROD_W = eavt_pkg::ANGLE_BITS + eavt_pkg::POLE_BITS;

    logic [PROD_W-1:0]               prod_full;
    logic [eavt_pkg::ANGLE_BITS-1:0] prod_turn;
    logic [eavt_pkg::ANGLE_BITS-1:0] prod_dir;

    // Scale by pole pairs; only the position within one electrical turn matters.
    assign prod_full = PROD_W'(raw_angle) * PROD_W'(cfg.pole_pairs);
    assign prod_turn = prod_full[eavt_pkg::ANGLE_BITS-1:0];

    // Optional direction flip, then remove the alignment offset, all modulo one turn.
    assign prod_dir   = cfg.reverse ? (eavt_pkg::ANGLE_BITS'(0) - prod_turn) : prod_turn;
    assign elec_angle = prod_dir - cfg.zero;

endmodule

@@ rtl/core/eavt_track.sv @@
// Tracking state: previous sample, filtered velocity and saturating turn accumulator.
module eavt_track (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                upd_en,
    input  logic                                mode,
    input  logic [eavt_pkg::ANGLE_BITS-1:0]     raw_angle,
    input  logic [eavt_pkg::ALPHA_BITS-1:0]     alpha,
    output eavt_pkg::eavt_track_t               trk_next
);

    localparam int DW     = eavt_pkg::ANGLE_BITS + 2;
    localparam int DIFF_W = eavt_pkg::VEL_BITS + 2;
    localparam int PROD_W = DIFF_W + eavt_pkg::ALPHA_BITS + 1;
    localparam int STEP_W = PROD_W - eavt_pkg::ALPHA_BITS;
    localparam int SUM_W  = STEP_W + 1;
    localparam int ACC_W  = eavt_pkg::ACCUM_BITS + 1;

    localparam logic signed [DW-1:0] HALF_TURN = DW'(1) <<< (eavt_pkg::ANGLE_BITS - 1);
    localparam logic signed [DW-1:0] FULL_TURN = DW'(1) <<< eavt_pkg::ANGLE_BITS;
    localparam logic signed [PROD_W-1:0] ROUND_HALF =
        PROD_W'(1) <<< (eavt_pkg::ALPHA_BITS - 1);
    localparam logic signed [SUM_W-1:0] VEL_MAX =
        (SUM_W'(1) <<< (eavt_pkg::VEL_BITS - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] VEL_MIN =
        -(SUM_W'(1) <<< (eavt_pkg::VEL_BITS - 1));
    localparam logic signed [ACC_W-1:0] ACC_MAX =
        (ACC_W'(1) <<< (eavt_pkg::ACCUM_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ACC_MIN =
        -(ACC_W'(1) <<< (eavt_pkg::ACCUM_BITS - 1));

    logic [eavt_pkg::ANGLE_BITS-1:0]          prev_reg;
    logic [eavt_pkg::ANGLE_BITS-1:0]          prev_next;
    logic signed [eavt_pkg::VEL_BITS-1:0]     vel_reg;
    logic signed [eavt_pkg::VEL_BITS-1:0]     vel_next;
    logic signed [eavt_pkg::ACCUM_BITS-1:0]   acc_reg;
    logic signed [eavt_pkg::ACCUM_BITS-1:0]   acc_next;

    logic signed [DW-1:0]                     delta_raw;
    logic signed [DW-1:0]                     delta;
    logic signed [DIFF_W-1:0]                 diff;
    logic signed [eavt_pkg::ALPHA_BITS:0]     alpha_s;
    logic signed [PROD_W-1:0]                 prod;
    logic signed [PROD_W-1:0]                 rounded;
    logic signed [STEP_W-1:0]                 step;
    logic signed [SUM_W-1:0]                  vel_sum;
    logic signed [SUM_W-1:0]                  vel_clamped;
    logic signed [ACC_W-1:0]                  acc_sum;
    logic signed [ACC_W-1:0]                  acc_clamped;

    // Sample delta, wrapped only when strictly beyond half a turn either way.
    always_comb begin
        delta_raw = $signed({2'b00, raw_angle}) - $signed({2'b00, prev_reg});
        if (delta_raw > HALF_TURN) begin
            delta = delta_raw - FULL_TURN;
        end else if (delta_raw < -HALF_TURN) begin
            delta = delta_raw + FULL_TURN;
        end else begin
            delta = delta_raw;
        end
    end

    // First-order low-pass: v += round((delta - v) * alpha), halves rounded up.
    assign diff    = (DIFF_W'(delta) <<< eavt_pkg::VEL_FRAC_BITS) - DIFF_W'(vel_reg);
    assign alpha_s = $signed({1'b0, alpha});
    assign prod    = diff * alpha_s;
    assign rounded = prod + ROUND_HALF;
    assign step    = $signed(rounded[PROD_W-1:eavt_pkg::ALPHA_BITS]);
    assign vel_sum = SUM_W'(step) + SUM_W'(vel_reg);

    always_comb begin
        if (vel_sum > VEL_MAX) begin
            vel_clamped = VEL_MAX;
        end else if (vel_sum < VEL_MIN) begin
            vel_clamped = VEL_MIN;
        end else begin
            vel_clamped = vel_sum;
        end
    end

    // Accumulated angle runs against the delta and saturates.
    assign acc_sum = ACC_W'(acc_reg) - ACC_W'(delta);

    always_comb begin
        if (acc_sum > ACC_MAX) begin
            acc_clamped = ACC_MAX;
        end else if (acc_sum < ACC_MIN) begin
            acc_clamped = ACC_MIN;
        end else begin
            acc_clamped = acc_sum;
        end
    end

    // Initialize keeps the velocity, clears the accumulator and takes the sample as previous.
    always_comb begin
        prev_next = raw_angle;
        if (mode == eavt_pkg::MODE_INIT) begin
            vel_next = vel_reg;
            acc_next = '0;
        end else begin
            vel_next = vel_clamped[eavt_pkg::VEL_BITS-1:0];
            acc_next = acc_clamped[eavt_pkg::ACCUM_BITS-1:0];
        end
    end

    assign trk_next.velocity = vel_next;
    assign trk_next.accum    = acc_next;

    // State update on every processed request that carries a good sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            vel_reg  <= '0;
            acc_reg  <= '0;
        end else if (upd_en) begin
            prev_reg <= prev_next;
            vel_reg  <= vel_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

@@ rtl/core/encoder_angle_velocity_tracker_unit.sv @@
// Top level of the encoder angle and velocity tracker with request and result registers.
// One request per clock cycle is accepted in steady state; s_ready falls only while a held
// request waits on a full result register that m_ready is stalling. An accepted request is
// held in the request register and its result is registered in the result register as soon
// as that slot is free or m_ready is high. The rate is set by the combinational tracking loop
// (delta wrap, velocity filter multiply and accumulator saturation) between the request
// register and the result register, since each sample needs the state left by the one before
// it. A request with read_failed set is consumed without a result and leaves the state alone.
// Configuration writes land at once and are meant to be made while no request is in flight.
module encoder_angle_velocity_tracker_unit (
    input  logic                                       aclk,
    input  logic                                       aresetn,

    input  logic                                       cfg_wr_en,
    input  logic [eavt_pkg::CFG_ADDR_BITS-1:0]         cfg_addr,
    input  logic [eavt_pkg::CFG_DATA_BITS-1:0]         cfg_wdata,

    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic                                       s_mode,
    input  logic [eavt_pkg::ANGLE_BITS-1:0]            s_raw_angle,
    input  logic                                       s_read_failed,

    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [eavt_pkg::ANGLE_BITS-1:0]            m_mechanical_angle,
    output logic [eavt_pkg::ANGLE_BITS-1:0]            m_electrical_angle,
    output logic signed [eavt_pkg::VEL_BITS-1:0]       m_filtered_velocity,
    output logic signed [eavt_pkg::ACCUM_BITS-1:0]     m_turn_accumulated_angle
);

    eavt_pkg::eavt_cfg_t                   cfg_reg;

    logic                                  in_valid_reg;
    logic                                  in_valid_next;
    logic                                  in_mode_reg;
    logic [eavt_pkg::ANGLE_BITS-1:0]       in_raw_reg;
    logic                                  in_failed_reg;

    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic [eavt_pkg::ANGLE_BITS-1:0]       out_mech_reg;
    logic [eavt_pkg::ANGLE_BITS-1:0]       out_elec_reg;
    logic signed [eavt_pkg::VEL_BITS-1:0]  out_vel_reg;
    logic signed [eavt_pkg::ACCUM_BITS-1:0] out_acc_reg;

    logic                                  in_accept;
    logic                                  advance;
    logic                                  produce;
    logic [eavt_pkg::ANGLE_BITS-1:0]       elec_angle;
    eavt_pkg::eavt_track_t                 trk_next;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha      <= eavt_pkg::ALPHA_RESET;
            cfg_reg.pole_pairs <= eavt_pkg::POLE_RESET;
            cfg_reg.reverse    <= 1'b0;
            cfg_reg.zero       <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                eavt_pkg::CFG_FILTER_ALPHA: begin
                    cfg_reg.alpha <= cfg_wdata[eavt_pkg::ALPHA_BITS-1:0];
                end
                eavt_pkg::CFG_POLE_PAIRS: begin
                    cfg_reg.pole_pairs <= cfg_wdata[eavt_pkg::POLE_BITS-1:0];
                end
                eavt_pkg::CFG_REVERSE_DIRECTION: begin
                    cfg_reg.reverse <= cfg_wdata[0];
                end
                eavt_pkg::CFG_ELECTRICAL_ZERO: begin
                    cfg_reg.zero <= cfg_wdata[eavt_pkg::ANGLE_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake: a held request moves on when the result slot frees up, or at once if it failed.
    assign advance        = in_valid_reg && (in_failed_reg || !out_valid_reg || m_ready);
    assign produce        = advance && !in_failed_reg;
    assign s_ready        = !in_valid_reg || advance;
    assign in_accept      = s_valid && s_ready;
    assign in_valid_next  = in_accept || (in_valid_reg && !advance);
    assign out_valid_next = produce || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request register.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_mode_reg   <= s_mode;
            in_raw_reg    <= s_raw_angle;
            in_failed_reg <= s_read_failed;
        end
    end

    // Electrical angle of the held sample.
    eavt_elec u_elec (
        .raw_angle  (in_raw_reg),
        .cfg        (cfg_reg),
        .elec_angle (elec_angle)
    );

    // Tracking state and its update for the held sample.
    eavt_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd_en    (produce),
        .mode      (in_mode_reg),
        .raw_angle (in_raw_reg),
        .alpha     (cfg_reg.alpha),
        .trk_next  (trk_next)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (produce) begin
            out_mech_reg <= in_raw_reg;
            out_elec_reg <= elec_angle;
            out_vel_reg  <= trk_next.velocity;
            out_acc_reg  <= trk_next.accum;
        end
    end

    assign m_valid                  = out_valid_reg;
    assign m_mechanical_angle       = out_mech_reg;
    assign m_electrical_angle       = out_elec_reg;
    assign m_filtered_velocity      = out_vel_reg;
    assign m_turn_accumulated_angle = out_acc_reg;

`ifndef SYNTHESIS
    // An initialize request always reports a cleared accumulator.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && (in_mode_reg == eavt_pkg::MODE_INIT)) |=> (m_turn_accumulated_angle == '0))
        else $error("initialize request did not clear the accumulated angle");

    // A failed read never creates a result on an empty output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_failed_reg && !m_valid) |=> !m_valid)
        else $error("failed read produced a result");

    // With the result slot empty, a held request never blocks the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !m_valid) |-> s_ready)
        else $error("input stalled while the result slot was empty");
`endif

endmodule
